// ===== hw/rtl/rllt_pkg.sv =====
// Shared types, sizes and helpers for the run-length line table.
package rllt_pkg;

    localparam int MAX_RUNS    = 256;
    localparam int OFFSET_BITS = 16;
    localparam int LINE_W      = 16;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int IDX_W       = $clog2(MAX_RUNS);
    localparam int CNT_W       = $clog2(MAX_RUNS + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Request codes
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // One run as held in the table memory
    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  len;
    } run_entry_t;

    localparam int ENTRY_W = $bits(run_entry_t);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } rllt_state_t;

    // Control from top level to the scanner
    typedef struct packed {
        logic                   start;
        logic [OFFSET_BITS-1:0] ofs;
    } scan_req_t;

    // Answer from the scanner
    typedef struct packed {
        logic              done;
        logic [LINE_W-1:0] line;
        logic              hit;
    } scan_rsp_t;

    // Saturating add on positions and lengths
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/run_length_line_table.sv =====
// Top level of the run-length line table: append logic, lookup control, output register.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | req_type, line_number, byte_offset
//  out     | out_valid | out_stall | line_out, offset_in_run, run_overflow
//
// An append writes its word into the output register, where it stands the next cycle.
// A lookup on an empty table is answered the same way. Otherwise the scanner reads
// the runs in order, from the first up to the first run holding the offset (or up to
// the last run on a miss), one run per cycle from the registered memory read port.
// One word is in work at a time; the next can be taken at the edge where the previous
// result leaves.
// Reset clears the run count, the state and the output valid flag; no clearing pass over the table memory.
// A stalled output blocks a new input word only while the output register is full.
module run_length_line_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [15:0]                 line_number,
    input  logic [15:0]                 byte_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 line_out,
    output logic                        offset_in_run,
    output logic                        run_overflow
);

    import rllt_pkg::*;

    rllt_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LINE_W-1:0]      last_line_reg;
    logic [POS_W-1:0]       last_start_reg;
    logic [POS_W-1:0]       last_len_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]      line_out_reg;
    logic                   in_run_reg;
    logic                   ovf_reg;

    logic                   accept;
    logic                   do_append;
    logic                   do_lookup;
    logic                   empty_lookup;
    logic                   need_new;
    logic                   full;
    logic                   new_run;
    run_entry_t             wr_entry;
    logic [IDX_W-1:0]       wr_addr;
    logic [CNT_W-1:0]       last_cnt;
    logic                   load_out;
    logic [LINE_W-1:0]      load_line;
    logic                   load_hit;
    logic                   load_ovf;

    scan_req_t              sreq;
    scan_rsp_t              srsp;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    run_entry_t             rd_data;
    logic [ENTRY_W-1:0]     rd_bits;

    assign accept       = in_valid && !in_stall;
    assign do_append    = accept && (req_type == REQ_APPEND);
    assign do_lookup    = accept && (req_type == REQ_LOOKUP);
    assign empty_lookup = do_lookup && (count_reg == '0);
    assign last_cnt     = count_reg - CNT_W'(1);

    // Append: new run or growth of the last run
    assign need_new = (count_reg == '0) || (last_line_reg < line_number);
    assign full     = (count_reg == CNT_W'(MAX_RUNS));
    assign new_run  = need_new && !full;

    always_comb
    begin
        if (new_run)
        begin
            wr_addr        = count_reg[IDX_W-1:0];
            wr_entry.line  = line_number;
            wr_entry.start = (count_reg == '0) ? '0 : sat_add(last_start_reg, last_len_reg);
            wr_entry.len   = POS_W'(1);
        end
        else
        begin
            wr_addr        = last_cnt[IDX_W-1:0];
            wr_entry.line  = last_line_reg;
            wr_entry.start = last_start_reg;
            wr_entry.len   = sat_add(last_len_reg, POS_W'(1));
        end
    end

    assign count_next = (do_append && new_run) ? count_reg + CNT_W'(1) : count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_lookup && !empty_lookup)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (srsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall   = 1'b1;
        sreq.start = 1'b0;
        sreq.ofs   = byte_offset[OFFSET_BITS-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = out_valid_reg && out_stall;
                sreq.start = do_lookup && !empty_lookup;
            end
            ST_SCAN:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Output register load
    always_comb
    begin
        load_out  = 1'b0;
        load_line = '0;
        load_hit  = 1'b0;
        load_ovf  = 1'b0;
        if (do_append)
        begin
            load_out = 1'b1;
            load_ovf = need_new && full;
        end
        else if (empty_lookup)
        begin
            load_out = 1'b1;
        end
        else if ((state_reg == ST_SCAN) && srsp.done)
        begin
            load_out  = 1'b1;
            load_line = srsp.line;
            load_hit  = srsp.hit;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Copy of the last run, so appends need no memory read
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            last_line_reg  <= wr_entry.line;
            last_start_reg <= wr_entry.start;
            last_len_reg   <= wr_entry.len;
        end
        if (load_out)
        begin
            line_out_reg <= load_line;
            in_run_reg   <= load_hit;
            ovf_reg      <= load_ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_out      = line_out_reg;
    assign offset_in_run = in_run_reg;
    assign run_overflow  = ovf_reg;

    // Run table memory; appends and scans never overlap
    rllt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RUNS)
    ) u_ram (
        .clk   (clk),
        .we    (do_append),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    assign rd_data = rd_bits;

    rllt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (sreq),
        .run_count (count_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rsp       (srsp)
    );

endmodule

// ===== hw/rtl/rllt_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module rllt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rllt_scan.sv =====
// Lookup scanner: streams runs out of the table memory and compares each.
module rllt_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rllt_pkg::scan_req_t       req,
    input  logic [rllt_pkg::CNT_W-1:0] run_count,
    output logic                      rd_en,
    output logic [rllt_pkg::IDX_W-1:0] rd_addr,
    input  rllt_pkg::run_entry_t      rd_data,
    output rllt_pkg::scan_rsp_t       rsp
);

    import rllt_pkg::*;

    logic [OFFSET_BITS-1:0] ofs_reg;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   issue_reg, issue_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [CNT_W-1:0]       last_cnt;
    logic [POS_W-1:0]       ofs_ext;
    logic [POS_W:0]         end_pos;
    logic                   hit;
    logic                   at_last;
    logic                   done;

    assign last_cnt = run_count - CNT_W'(1);

    // Compare stage: the entry read last cycle
    assign ofs_ext = {1'b0, ofs_reg};
    assign end_pos = {1'b0, rd_data.start} + {1'b0, rd_data.len};
    assign hit     = (ofs_ext >= rd_data.start) && ({1'b0, ofs_ext} < end_pos);
    assign at_last = ({1'b0, cmp_idx_reg} == last_cnt);
    assign done    = cmp_valid_reg && (hit || at_last);

    assign rsp.done = done;
    assign rsp.line = rd_data.line;
    assign rsp.hit  = hit;

    assign rd_en   = issue_reg;
    assign rd_addr = rd_idx_reg;

    // Issue and compare control
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        issue_next     = issue_reg;
        cmp_valid_next = issue_reg && !done;
        if (req.start)
        begin
            rd_idx_next    = '0;
            issue_next     = 1'b1;
            cmp_valid_next = 1'b0;
        end
        else if (done)
        begin
            issue_next = 1'b0;
        end
        else if (issue_reg)
        begin
            // stop issuing once the last valid run has been read
            if ({1'b0, rd_idx_reg} == last_cnt)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ofs_reg <= req.ofs;
        end
        cmp_idx_reg <= rd_idx_reg;
    end

endmodule

// ===== hw/rtl/rllt_checker.sv =====
// Port-level checks for the run-length line table, bound to the top level.
module rllt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic [15:0] line_number,
    input logic [15:0] byte_offset,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] line_out,
    input logic        offset_in_run,
    input logic        run_overflow
);

    import rllt_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Words accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_out)
            && $stable(offset_in_run) && $stable(run_overflow))
        else $error("output word changed while stalled");

    // Only one word in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (pending_reg == 2'd0) || ((pending_reg == 2'd1) && out_acc))
        else $error("input taken while a word is still in work");

    // Append result appears the next cycle, with lookup fields cleared
    a_append_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (req_type == REQ_APPEND) |=> out_valid && !offset_in_run
            && (line_out == 16'd0))
        else $error("append result missing or malformed");

    // A word cannot be both a lookup hit and an append overflow
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(offset_in_run && run_overflow))
        else $error("hit and overflow flags both set");

    // No result without a word in work
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result word with nothing in work");

endmodule

bind run_length_line_table rllt_checker u_rllt_checker (.*);
